// ===== design/ptwr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwr_pkg
// Shared types and constants for the packet tic window receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwr_pkg;

  localparam int TIC_W  = 31;
  localparam int WIDE_W = 33;  // widened tics may fall below 0 or above 2^31-1

  typedef logic [TIC_W-1:0]         tic_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // configuration register indexes
  localparam logic REG_ACTIVE_NODES = 1'b0;
  localparam logic REG_RESEND_HOLD  = 1'b1;

  localparam logic [3:0] RESEND_HOLD_RST = 4'd10;

  typedef enum logic [2:0] {
    V_SETUP     = 3'd0,
    V_EXIT      = 3'd1,
    V_EXIT_IGN  = 3'd2,
    V_KILL      = 3'd3,
    V_DUPLICATE = 3'd4,
    V_STALE     = 3'd5,
    V_GAP       = 3'd6,
    V_ACCEPT    = 3'd7
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_IGNORE = 2'd0,
    KIND_EXIT   = 2'd1,
    KIND_KILL   = 2'd2,
    KIND_DATA   = 2'd3
  } pkt_kind_e;

  // classified packet passed from front to back
  typedef struct packed {
    pkt_kind_e   kind;
    logic        node_ok;
    logic [2:0]  node;
    logic [1:0]  player;
    logic        retx;
    wide_t       rstart;
    wide_t       rend;
    tic_t        retx_tic;
  } item_t;

endpackage

`default_nettype wire

// ===== design/ptwr_front.sv =====
// ----------------------------------------------------------------------------
// ptwr_front
// Accepts packet headers, widens the tic bytes and classifies the packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwr_front #(
  parameter int NODES        = 8,
  parameter int WIDEN_WINDOW = 64
) (
  input  wire logic           start_i,
  input  wire logic           full_i,
  input  wire logic           is_setup_i,
  input  wire logic           is_exit_i,
  input  wire logic           is_retransmit_i,
  input  wire logic           is_kill_i,
  input  wire logic [2:0]     sender_node_i,
  input  wire logic [1:0]     sender_player_i,
  input  wire logic [7:0]     start_low_i,
  input  wire logic [7:0]     command_count_i,
  input  wire logic [7:0]     retransmit_low_i,
  input  wire logic [30:0]    local_tic_i,
  output logic                busy_o,
  output logic                push_o,
  output ptwr_pkg::item_t     item_o
);
  import ptwr_pkg::*;

  localparam logic signed [9:0] WIN = 10'(WIDEN_WINDOW);

  // tic with low byte lo beside local_tic; moved by 256 when the low bytes differ by over WIDEN_WINDOW
  function automatic wide_t widen(input logic [7:0] lo, input tic_t local_tic);
    wide_t             base;
    wide_t             near;
    logic signed [9:0] delta;
    base  = {2'b00, local_tic[30:8], 8'h00};
    near  = base + wide_t'({25'd0, lo});
    delta = $signed({2'b00, lo}) - $signed({2'b00, local_tic[7:0]});
    if (delta > WIN) begin
      widen = near - wide_t'(256);
    end else if (delta < -WIN) begin
      widen = near + wide_t'(256);
    end else begin
      widen = near;
    end
  endfunction

  wide_t rstart;
  wide_t rretx;

  always_comb begin
    rstart = widen(start_low_i, local_tic_i);
    rretx  = widen(retransmit_low_i, local_tic_i);

    if (is_setup_i) begin
      item_o.kind = KIND_IGNORE;
    end else if (is_exit_i) begin
      item_o.kind = KIND_EXIT;
    end else if (is_kill_i) begin
      item_o.kind = KIND_KILL;
    end else begin
      item_o.kind = KIND_DATA;
    end
    item_o.node_ok  = 32'(sender_node_i) < NODES;
    item_o.node     = sender_node_i;
    item_o.player   = sender_player_i;
    item_o.retx     = is_retransmit_i;
    item_o.rstart   = rstart;
    item_o.rend     = rstart + wide_t'({25'd0, command_count_i});
    item_o.retx_tic = rretx[TIC_W-1:0];
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

endmodule

`default_nettype wire

// ===== design/ptwr_queue.sv =====
// ----------------------------------------------------------------------------
// ptwr_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwr_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ptwr_pkg::item_t  item_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output ptwr_pkg::item_t       head_o
);
  import ptwr_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== design/ptwr_back.sv =====
// ----------------------------------------------------------------------------
// ptwr_back
// Per-node tic table: read-modify-write of one node per transaction and
// registered result; a same-cycle configuration write drops the table update.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwr_back #(
  parameter int NODES   = 8,
  parameter int PLAYERS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [3:0]       cfg_wdata_i,
  input  wire logic             empty_i,
  input  wire ptwr_pkg::item_t  head_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  output logic [2:0]            verdict_o,
  output logic                  player_left_o,
  output logic [7:0]            skip_commands_o,
  output logic [7:0]            take_commands_o,
  output logic [30:0]           first_store_tic_o,
  output logic [30:0]           new_expected_tic_o,
  output logic                  resend_armed_o,
  output logic [30:0]           resend_from_tic_o,
  output logic                  need_resend_o
);
  import ptwr_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

  tic_t        exp_q    [NODES];
  logic        gone_q   [NODES];
  logic        miss_q   [NODES];
  tic_t        rsnd_q   [NODES];
  logic [3:0]  hold_q   [NODES];
  logic [2:0]  nop_q    [PLAYERS];
  logic [3:0]  resend_hold_q;

  logic [NW-1:0] idx;
  logic [PW-1:0] pidx;
  logic          player_ok;
  wide_t         exp_s;

  tic_t        exp_d;
  logic        gone_d;
  logic        miss_d;
  tic_t        rsnd_d;
  logic [3:0]  hold_d;
  logic        nop_we;

  verdict_e    verdict;
  logic        left;
  logic [7:0]  skip;
  logic [7:0]  take;
  tic_t        first;
  logic        armed;

  assign pop_o = !empty_i;

  always_comb begin
    idx       = NW'(head_i.node);
    pidx      = PW'(head_i.player);
    player_ok = 32'(head_i.player) < PLAYERS;
    exp_s     = wide_t'({2'b00, exp_q[idx]});

    exp_d   = exp_q[idx];
    gone_d  = gone_q[idx];
    miss_d  = miss_q[idx];
    rsnd_d  = rsnd_q[idx];
    hold_d  = hold_q[idx];
    nop_we  = 1'b0;
    verdict = V_SETUP;
    left    = 1'b0;
    skip    = 8'd0;
    take    = 8'd0;
    first   = '0;
    armed   = 1'b0;

    if (head_i.node_ok) begin
      case (head_i.kind)
        KIND_IGNORE: verdict = V_SETUP;
        KIND_EXIT: begin
          if (gone_q[idx]) begin
            verdict = V_EXIT_IGN;
          end else begin
            gone_d  = 1'b1;
            left    = 1'b1;
            verdict = V_EXIT;
          end
        end
        KIND_KILL: verdict = V_KILL;
        KIND_DATA: begin
          nop_we = player_ok;
          if (hold_q[idx] == 4'd0 && head_i.retx) begin
            rsnd_d = head_i.retx_tic;
            hold_d = resend_hold_q;
            armed  = 1'b1;
          end else if (hold_q[idx] != 4'd0) begin
            hold_d = hold_q[idx] - 4'd1;
          end

          if (head_i.rend == exp_s) begin
            verdict = V_DUPLICATE;
          end else if (head_i.rend < exp_s) begin
            verdict = V_STALE;
          end else if (head_i.rstart > exp_s) begin
            miss_d  = 1'b1;
            verdict = V_GAP;
          end else begin
            miss_d  = 1'b0;
            verdict = V_ACCEPT;
            skip    = 8'(exp_s - head_i.rstart);
            take    = 8'(head_i.rend - exp_s);
            first   = exp_q[idx];
            exp_d   = head_i.rend[TIC_W-1:0];
          end
        end
        default: verdict = V_SETUP;
      endcase
    end
  end

  // node table; a write of active_nodes rebuilds the out-of-game flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        exp_q[i]  <= '0;
        gone_q[i] <= (i >= 1);
        miss_q[i] <= 1'b0;
        rsnd_q[i] <= '0;
        hold_q[i] <= 4'd0;
      end
      for (int i = 0; i < PLAYERS; i++) begin
        nop_q[i] <= 3'd0;
      end
      resend_hold_q <= RESEND_HOLD_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACTIVE_NODES: begin
            for (int i = 0; i < NODES; i++) begin
              gone_q[i] <= 32'(i) >= 32'(cfg_wdata_i);
            end
          end
          REG_RESEND_HOLD: resend_hold_q <= cfg_wdata_i;
          default: ;
        endcase
      end else if (pop_o && head_i.node_ok) begin
        exp_q[idx]  <= exp_d;
        gone_q[idx] <= gone_d;
        miss_q[idx] <= miss_d;
        rsnd_q[idx] <= rsnd_d;
        hold_q[idx] <= hold_d;
        if (nop_we) begin
          nop_q[pidx] <= head_i.node;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_o          <= verdict;
      player_left_o      <= left;
      skip_commands_o    <= skip;
      take_commands_o    <= take;
      first_store_tic_o  <= first;
      resend_armed_o     <= armed;
      new_expected_tic_o <= head_i.node_ok ? exp_d : '0;
      resend_from_tic_o  <= head_i.node_ok ? rsnd_d : '0;
      need_resend_o      <= head_i.node_ok && miss_d;
    end
  end

  a_counts_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && verdict_o != V_ACCEPT |-> skip_commands_o == 8'd0 &&
      take_commands_o == 8'd0)
    else $error("command counts on a non-accepted transaction");

  a_player_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !cfg_we_i && head_i.node_ok && head_i.kind == KIND_DATA && player_ok
      |=> nop_q[$past(pidx)] == $past(head_i.node))
    else $error("player to node map not updated");

  a_armed_needs_retx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && armed |-> head_i.retx && hold_q[idx] == 4'd0)
    else $error("resend armed while held off");

endmodule

`default_nettype wire

// ===== design/packet_tic_window_receiver.sv =====
// ----------------------------------------------------------------------------
// packet_tic_window_receiver
// The result strobe is registered after the header passes through the queue.
// Throughput: one header per cycle unless busy_o; the back end retires one
// queued header per cycle by a single read-modify-write of the per-node table.
// Reset: table cleared, only node 0 in game, resend hold 10, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_tic_window_receiver #(
  parameter int NODES        = 8,
  parameter int PLAYERS      = 4,
  parameter int WIDEN_WINDOW = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [3:0]   cfg_wdata_i,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire logic         is_setup_i,
  input  wire logic         is_exit_i,
  input  wire logic         is_retransmit_i,
  input  wire logic         is_kill_i,
  input  wire logic [2:0]   sender_node_i,
  input  wire logic [1:0]   sender_player_i,
  input  wire logic [7:0]   start_low_i,
  input  wire logic [7:0]   command_count_i,
  input  wire logic [7:0]   retransmit_low_i,
  input  wire logic [30:0]  local_tic_i,
  output logic              result_valid_o,
  output logic [2:0]        verdict_o,
  output logic              player_left_o,
  output logic [7:0]        skip_commands_o,
  output logic [7:0]        take_commands_o,
  output logic [30:0]       first_store_tic_o,
  output logic [30:0]       new_expected_tic_o,
  output logic              resend_armed_o,
  output logic [30:0]       resend_from_tic_o,
  output logic              need_resend_o
);
  import ptwr_pkg::*;

  item_t  front_item;
  item_t  head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  ptwr_front #(
    .NODES        (NODES),
    .WIDEN_WINDOW (WIDEN_WINDOW)
  ) u_front (
    .start_i          (start_i),
    .full_i           (full),
    .is_setup_i       (is_setup_i),
    .is_exit_i        (is_exit_i),
    .is_retransmit_i  (is_retransmit_i),
    .is_kill_i        (is_kill_i),
    .sender_node_i    (sender_node_i),
    .sender_player_i  (sender_player_i),
    .start_low_i      (start_low_i),
    .command_count_i  (command_count_i),
    .retransmit_low_i (retransmit_low_i),
    .local_tic_i      (local_tic_i),
    .busy_o           (busy_o),
    .push_o           (push),
    .item_o           (front_item)
  );

  ptwr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  ptwr_back #(
    .NODES   (NODES),
    .PLAYERS (PLAYERS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .empty_i            (empty),
    .head_i             (head),
    .pop_o              (pop),
    .result_valid_o     (result_valid_o),
    .verdict_o          (verdict_o),
    .player_left_o      (player_left_o),
    .skip_commands_o    (skip_commands_o),
    .take_commands_o    (take_commands_o),
    .first_store_tic_o  (first_store_tic_o),
    .new_expected_tic_o (new_expected_tic_o),
    .resend_armed_o     (resend_armed_o),
    .resend_from_tic_o  (resend_from_tic_o),
    .need_resend_o      (need_resend_o)
  );

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 result_valid_o)
    else $error("result missing two cycles after start transaction");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pop))
    else $error("result strobe without queued transaction");

endmodule

`default_nettype wire
